// ===== rtl/kvcr_pkg.sv =====
// ----------------------------------------------------------------------------
// kvcr_pkg
// Shared sizes, codes and cell interface types for the key-value cache.
// ----------------------------------------------------------------------------
package kvcr_pkg;

	localparam int ENTRIES    = 16;
	localparam int KEY_BITS   = 32;
	localparam int VALUE_BITS = 32;

	localparam int RANK_BITS = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
	localparam int OCC_BITS  = $clog2(ENTRIES + 1);
	localparam int CAP_BITS  = 5;
	localparam int CMP_BITS  = (OCC_BITS > CAP_BITS) ? OCC_BITS : CAP_BITS;

	typedef logic [1:0] action_t;
	localparam action_t ACT_INSERT = 2'd0;
	localparam action_t ACT_QUERY  = 2'd1;

	typedef logic [1:0] policy_t;
	localparam policy_t POL_FIFO = 2'd1;
	localparam policy_t POL_LIFO = 2'd2;

	typedef logic [0:0] cfg_idx_t;
	localparam cfg_idx_t CFG_POLICY   = 1'b0;
	localparam cfg_idx_t CFG_CAPACITY = 1'b1;

	// broadcast from the controller to every cell
	typedef struct packed {
		logic                  look;
		logic                  upd;
		logic [KEY_BITS-1:0]   key;
		logic [VALUE_BITS-1:0] value;
		logic                  lru;
		logic                  query_front;
		logic                  insert;
		logic                  evict;
		logic [RANK_BITS-1:0]  hit_rank;
		logic [RANK_BITS-1:0]  target;
		logic [RANK_BITS-1:0]  new_rank;
	} cell_cmd_t;

	// lookup result, ORed cell to cell along the row
	typedef struct packed {
		logic                  hit;
		logic [RANK_BITS-1:0]  rank;
		logic [VALUE_BITS-1:0] value;
	} cell_stat_t;

endpackage

// ===== rtl/key_value_cache_replacement.sv =====
// An accepted input word passes lookup and registered compare, then the row
// update, which registers its result; a new word is accepted only when idle.
// The output register frees the input side while a result waits under stall.
// Reset (arst_n low): all entries invalid, ranks and occupancy zero,
// policy least recently used, capacity 16. No clearing pass is needed.
// ----------------------------------------------------------------------------
// key_value_cache_replacement
// Fully associative key-value store over a row of entry cells with LRU,
// FIFO or LIFO replacement.
// ----------------------------------------------------------------------------
module key_value_cache_replacement (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                cfg_valid,
	output logic                                cfg_ready,
	input  kvcr_pkg::cfg_idx_t                  cfg_index,
	input  logic [kvcr_pkg::CAP_BITS-1:0]       cfg_data,
	input  logic                                in_valid,
	output logic                                in_stall,
	input  kvcr_pkg::action_t                   action,
	input  logic [kvcr_pkg::KEY_BITS-1:0]       key,
	input  logic [kvcr_pkg::VALUE_BITS-1:0]     value,
	output logic                                out_valid,
	input  logic                                out_stall,
	output logic                                hit,
	output logic [kvcr_pkg::VALUE_BITS-1:0]     read_value,
	output logic                                evicted
);
	import kvcr_pkg::*;

	typedef enum logic [2:0] {
		S_IDLE = 3'b001,
		S_LOOK = 3'b010,
		S_UPD  = 3'b100
	} state_t;

	state_t                state_q;
	action_t               act_q;
	logic [KEY_BITS-1:0]   key_q;
	logic [VALUE_BITS-1:0] value_q;
	logic                  lk_hit_q;
	logic [RANK_BITS-1:0]  hit_rank_q;
	logic [VALUE_BITS-1:0] hit_value_q;
	logic                  evict_q;
	policy_t               policy_q;
	logic [CAP_BITS-1:0]   capacity_q;
	logic [OCC_BITS-1:0]   occ_q;
	logic                  out_valid_q;
	logic                  hit_q;
	logic [VALUE_BITS-1:0] read_value_q;
	logic                  evicted_q;

	logic                  lru;
	logic                  fifo;
	logic                  is_insert;
	logic                  is_query;
	logic [CMP_BITS-1:0]   cap_ext;
	logic [CMP_BITS-1:0]   cap_eff;
	logic                  full;
	logic                  fire;
	cell_cmd_t             cmd;

	cell_stat_t            stat_chain [ENTRIES+1];
	logic [ENTRIES:0]      free_chain;
	logic [ENTRIES-1:0]    valid_vec;
	logic [ENTRIES-1:0]    take_vec;

	assign cfg_ready  = 1'b1;
	assign in_stall   = (state_q != S_IDLE);
	assign out_valid  = out_valid_q;
	assign hit        = hit_q;
	assign read_value = read_value_q;
	assign evicted    = evicted_q;

	assign fifo      = (policy_q == POL_FIFO);
	assign lru       = !(fifo || (policy_q == POL_LIFO));
	assign is_insert = (act_q == ACT_INSERT);
	assign is_query  = (act_q == ACT_QUERY);
	assign cap_ext   = CMP_BITS'(capacity_q);

	always_comb begin
		cap_eff = cap_ext;
		if (cap_ext == '0) begin
			cap_eff = CMP_BITS'(1);
		end else if (cap_ext > CMP_BITS'(ENTRIES)) begin
			cap_eff = CMP_BITS'(ENTRIES);
		end
	end

	assign full = (CMP_BITS'(occ_q) >= cap_eff);
	assign fire = !out_valid_q || !out_stall;

	always_comb begin
		cmd.look        = (state_q == S_LOOK);
		cmd.upd         = (state_q == S_UPD) && fire;
		cmd.key         = key_q;
		cmd.value       = value_q;
		cmd.lru         = lru;
		cmd.query_front = is_query && lk_hit_q && lru;
		cmd.insert      = is_insert && !lk_hit_q;
		cmd.evict       = evict_q;
		cmd.hit_rank    = hit_rank_q;
		// FIFO evicts the head of the list, LRU and LIFO the tail
		cmd.target      = fifo ? '0 : RANK_BITS'(occ_q - OCC_BITS'(1));
		cmd.new_rank    = lru ? '0 : RANK_BITS'(occ_q - OCC_BITS'(evict_q));
	end

	assign stat_chain[0] = '0;
	assign free_chain[0] = 1'b0;
	assign take_vec      = free_chain[ENTRIES:1] & ~free_chain[ENTRIES-1:0];

	for (genvar i = 0; i < ENTRIES; i++) begin : g_cell
		kvcr_cell u_cell (
			.clk      (clk),
			.arst_n   (arst_n),
			.cmd      (cmd),
			.free_in  (free_chain[i]),
			.free_out (free_chain[i+1]),
			.stat_in  (stat_chain[i]),
			.stat_out (stat_chain[i+1]),
			.valid    (valid_vec[i])
		);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			policy_q    <= '0;
			capacity_q  <= CAP_BITS'(16);
			occ_q       <= '0;
			out_valid_q <= 1'b0;
			lk_hit_q    <= 1'b0;
			evict_q     <= 1'b0;
		end else begin
			if (cfg_valid) begin
				case (cfg_index)
					CFG_POLICY:   policy_q   <= cfg_data[1:0];
					CFG_CAPACITY: capacity_q <= cfg_data;
					default: ;
				endcase
			end

			if (cmd.upd) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end

			case (state_q)
				S_IDLE: begin
					if (in_valid) begin
						state_q <= S_LOOK;
					end
				end
				S_LOOK: begin
					lk_hit_q <= stat_chain[ENTRIES].hit;
					evict_q  <= is_insert && !stat_chain[ENTRIES].hit && full;
					state_q  <= S_UPD;
				end
				S_UPD: begin
					if (fire) begin
						if (cmd.insert) begin
							occ_q <= occ_q - OCC_BITS'(evict_q) + OCC_BITS'(1);
						end
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == S_IDLE && in_valid) begin
			act_q   <= action;
			key_q   <= key;
			value_q <= value;
		end
		if (state_q == S_LOOK) begin
			hit_rank_q  <= stat_chain[ENTRIES].rank;
			hit_value_q <= stat_chain[ENTRIES].value;
		end
		if (cmd.upd) begin
			hit_q        <= lk_hit_q;
			read_value_q <= (is_query && lk_hit_q) ? hit_value_q : '0;
			evicted_q    <= evict_q;
		end
	end

`ifndef NO_ASSERTIONS
	a_occ_matches_valid: assert property (@(posedge clk) disable iff (!arst_n)
		$countones(valid_vec) == int'(occ_q))
		else $error("occupancy differs from number of valid entries");

	a_one_slot_taken: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.upd && cmd.insert |-> $onehot(take_vec))
		else $error("insert did not find exactly one free slot");

	a_evict_not_hit: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> !(hit && evicted))
		else $error("eviction reported on a hit");

	a_value_needs_hit: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (read_value != '0) |-> hit)
		else $error("nonzero read value without hit");

	a_look_then_upd: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_LOOK |=> state_q == S_UPD)
		else $error("lookup not followed by update");
`endif

endmodule

// ===== rtl/kvcr_cell.sv =====
// ----------------------------------------------------------------------------
// kvcr_cell
// One cache entry: key, value and order rank, with local compare and update.
// ----------------------------------------------------------------------------
module kvcr_cell (
	input  logic                clk,
	input  logic                arst_n,
	input  kvcr_pkg::cell_cmd_t cmd,
	input  logic                free_in,
	output logic                free_out,
	input  kvcr_pkg::cell_stat_t stat_in,
	output kvcr_pkg::cell_stat_t stat_out,
	output logic                valid
);
	import kvcr_pkg::*;

	logic                  valid_q;
	logic [KEY_BITS-1:0]   key_q;
	logic [VALUE_BITS-1:0] value_q;
	logic [RANK_BITS-1:0]  rank_q;
	logic                  match_q;
	logic                  victim_q;

	logic                  match;
	logic                  victim;
	logic                  free_here;
	logic                  take;
	logic [RANK_BITS-1:0]  rank_dec;

	assign match     = valid_q && (key_q == cmd.key);
	assign victim    = valid_q && (rank_q == cmd.target);
	assign free_here = !valid_q || (cmd.evict && victim_q);
	// lowest free slot along the row takes the new entry
	assign take      = cmd.insert && free_here && !free_in;
	assign free_out  = free_in || free_here;
	assign rank_dec  = (cmd.evict && (rank_q > cmd.target)) ? rank_q - 1'b1 : rank_q;
	assign valid     = valid_q;

	always_comb begin
		stat_out.hit   = stat_in.hit || match;
		stat_out.rank  = stat_in.rank | (match ? rank_q : '0);
		stat_out.value = stat_in.value | (match ? value_q : '0);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q  <= 1'b0;
			rank_q   <= '0;
			match_q  <= 1'b0;
			victim_q <= 1'b0;
		end else begin
			if (cmd.look) begin
				match_q  <= match;
				victim_q <= victim;
			end
			if (cmd.upd) begin
				if (cmd.query_front) begin
					if (match_q) begin
						rank_q <= '0;
					end else if (valid_q && (rank_q < cmd.hit_rank)) begin
						rank_q <= rank_q + 1'b1;
					end
				end else if (cmd.insert) begin
					if (take) begin
						valid_q <= 1'b1;
						rank_q  <= cmd.new_rank;
					end else if (cmd.evict && victim_q) begin
						valid_q <= 1'b0;
					end else if (valid_q) begin
						rank_q <= cmd.lru ? rank_dec + 1'b1 : rank_dec;
					end
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.upd && take) begin
			key_q   <= cmd.key;
			value_q <= cmd.value;
		end
	end

endmodule

// ===== tb/sv/testbench.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the key-value cache. A queue of operations feeds a
// bursty driver, a scoreboard predicts hit, read value and eviction for every
// accepted word, and the receiver stalls on a changing pattern with one long
// hold-off. Policy and capacity are rewritten between phases while idle.
// ----------------------------------------------------------------------------
module testbench;
	import kvcr_pkg::*;

	localparam action_t ACT_CHECK   = 2'd2;
	localparam action_t ACT_SPARE   = 2'd3;
	localparam policy_t POL_LRU     = 2'd0;
	localparam int      HALF_PERIOD = 6;
	localparam int      POOL_SIZE   = 24;
	localparam int      PHASES      = 12;
	localparam int      PHASE_OPS   = 162;
	localparam int      CAP_PLAN [PHASES] = '{16, 1, 2, 4, 8, 31, 0, 3, 17, 12, 16, 5};

	typedef struct {
		action_t               act;
		logic [KEY_BITS-1:0]   k;
		logic [VALUE_BITS-1:0] v;
	} cache_op_t;

	typedef struct {
		logic                  hit;
		logic [VALUE_BITS-1:0] rd;
		logic                  ev;
	} lookup_res_t;

	typedef enum int {RX_FREE, RX_LIGHT, RX_HEAVY, RX_TOGGLE} rx_mode_t;

	logic                  clk = 1'b0;
	logic                  arst_n;
	logic                  cfg_valid;
	logic                  cfg_ready;
	cfg_idx_t              cfg_index;
	logic [CAP_BITS-1:0]   cfg_data;
	logic                  in_valid;
	logic                  in_stall;
	action_t               action;
	logic [KEY_BITS-1:0]   key;
	logic [VALUE_BITS-1:0] value;
	logic                  out_valid;
	logic                  out_stall;
	logic                  hit;
	logic [VALUE_BITS-1:0] read_value;
	logic                  evicted;

	// scoreboard copy of the store
	logic                  ent_used [ENTRIES];
	logic [KEY_BITS-1:0]   ent_key  [ENTRIES];
	logic [VALUE_BITS-1:0] ent_val  [ENTRIES];
	int unsigned           ent_rank [ENTRIES];
	int unsigned           ent_fill;
	policy_t               cur_policy;
	int unsigned           cur_cap;

	cache_op_t             cache_ops[$];
	lookup_res_t           lookup_expect[$];
	logic [KEY_BITS-1:0]   key_pool [POOL_SIZE];
	logic                  op_taken;
	int                    burst_left;
	int                    gap_left;
	int                    hold_req;
	int                    hold_seen;
	int                    hold_left;
	int                    mode_left;
	rx_mode_t              stall_mode;
	int                    err_cnt;

	key_value_cache_replacement u_dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_valid  (cfg_valid),
		.cfg_ready  (cfg_ready),
		.cfg_index  (cfg_index),
		.cfg_data   (cfg_data),
		.in_valid   (in_valid),
		.in_stall   (in_stall),
		.action     (action),
		.key        (key),
		.value      (value),
		.out_valid  (out_valid),
		.out_stall  (out_stall),
		.hit        (hit),
		.read_value (read_value),
		.evicted    (evicted)
	);

	always #HALF_PERIOD clk = ~clk;

	function automatic void note_error(string msg);
		err_cnt++;
		if (err_cnt <= 10)
			$display("ERROR: %s", msg);
	endfunction

	function automatic void drop_entry(int s);
		int unsigned r;
		int i;
		r = ent_rank[s];
		ent_used[s] = 1'b0;
		for (i = 0; i < ENTRIES; i++)
			if (ent_used[i] && ent_rank[i] > r)
				ent_rank[i]--;
		if (ent_fill > 0)
			ent_fill--;
	endfunction

	// rank 0 is most recent under LRU; FIFO/LIFO append at the tail
	function automatic lookup_res_t predict_lookup(cache_op_t op);
		lookup_res_t res;
		int found;
		int free_slot;
		int i;
		int unsigned cap;
		int unsigned victim;
		int unsigned r;
		logic fifo;
		logic lru;
		found = -1;
		free_slot = -1;
		for (i = 0; i < ENTRIES; i++)
			if (found < 0 && ent_used[i] && ent_key[i] == op.k)
				found = i;
		fifo = (cur_policy == POL_FIFO);
		lru = (cur_policy != POL_FIFO) && (cur_policy != POL_LIFO);
		cap = (cur_cap == 0) ? 1 : (cur_cap > ENTRIES) ? ENTRIES : cur_cap;
		res.hit = (found >= 0);
		res.rd = '0;
		res.ev = 1'b0;
		if (op.act == ACT_INSERT) begin
			if (found < 0) begin
				if (ent_fill >= cap && ent_fill > 0) begin
					victim = fifo ? 0 : ent_fill - 1;
					for (i = 0; i < ENTRIES; i++) begin
						if (ent_used[i] && ent_rank[i] == victim) begin
							drop_entry(i);
							res.ev = 1'b1;
							break;
						end
					end
				end
				for (i = 0; i < ENTRIES; i++)
					if (free_slot < 0 && !ent_used[i])
						free_slot = i;
				if (free_slot >= 0) begin
					if (lru) begin
						for (i = 0; i < ENTRIES; i++)
							if (ent_used[i])
								ent_rank[i]++;
						ent_rank[free_slot] = 0;
					end else begin
						ent_rank[free_slot] = ent_fill;
					end
					ent_used[free_slot] = 1'b1;
					ent_key[free_slot] = op.k;
					ent_val[free_slot] = op.v;
					ent_fill++;
				end
			end
		end else if (op.act == ACT_QUERY && found >= 0) begin
			res.rd = ent_val[found];
			if (lru) begin
				r = ent_rank[found];
				for (i = 0; i < ENTRIES; i++)
					if (ent_used[i] && ent_rank[i] < r)
						ent_rank[i]++;
				ent_rank[found] = 0;
			end
		end
		return res;
	endfunction

	// keys mostly from a small pool so hits and evictions are frequent
	function automatic cache_op_t rand_op(int span);
		cache_op_t op;
		int unsigned r;
		r = $urandom_range(0, 99);
		op.act = (r < 45) ? ACT_INSERT : (r < 75) ? ACT_QUERY : (r < 95) ? ACT_CHECK : ACT_SPARE;
		op.k = ($urandom_range(0, 6) == 0) ? $urandom : key_pool[$urandom_range(0, span - 1)];
		r = $urandom_range(0, 9);
		op.v = (r == 0) ? '0 : (r == 1) ? '1 : $urandom;
		return op;
	endfunction

	task automatic queue_op(action_t a, logic [KEY_BITS-1:0] k, logic [VALUE_BITS-1:0] v);
		cache_op_t op;
		op.act = a;
		op.k = k;
		op.v = v;
		cache_ops.push_back(op);
	endtask

	task automatic wait_drained();
		do @(negedge clk); while (cache_ops.size() != 0 || lookup_expect.size() != 0);
		repeat (6) @(negedge clk);
	endtask

	task automatic write_reg(cfg_idx_t idx, logic [CAP_BITS-1:0] data);
		@(negedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		do @(posedge clk); while (!cfg_ready);
		if (idx == CFG_POLICY)
			cur_policy = policy_t'(data[1:0]);
		else
			cur_cap = data;
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	// sender: bursts of words separated by random gaps; a held word stays put
	always @(negedge clk) begin : drive_ops
		logic was_taken;
		was_taken = op_taken;
		if (op_taken) begin
			void'(cache_ops.pop_front());
			op_taken = 1'b0;
		end
		if (!arst_n) begin
			in_valid <= 1'b0;
		end else if (in_valid && !was_taken) begin
			// stalled: keep valid and payload
		end else if (gap_left > 0) begin
			gap_left--;
			in_valid <= 1'b0;
		end else if (cache_ops.size() == 0) begin
			in_valid <= 1'b0;
		end else begin
			in_valid <= 1'b1;
			action <= cache_ops[0].act;
			key <= cache_ops[0].k;
			value <= cache_ops[0].v;
			if (burst_left > 0) begin
				burst_left--;
			end else begin
				burst_left = $urandom_range(0, 24);
				gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 7);
			end
		end
	end

	// receiver: stall pattern changes every so often; hold_req forces a long hold-off
	always @(negedge clk) begin : drive_stall
		logic nxt;
		if (hold_req != hold_seen) begin
			hold_seen = hold_req;
			hold_left = 240;
		end else if (hold_left == 0 && $urandom_range(0, 599) == 0) begin
			hold_left = $urandom_range(20, 60);
		end
		if (mode_left == 0) begin
			stall_mode = rx_mode_t'($urandom_range(0, 3));
			mode_left = $urandom_range(10, 120);
		end else begin
			mode_left--;
		end
		if (hold_left > 0) begin
			nxt = 1'b1;
			hold_left--;
		end else begin
			case (stall_mode)
				RX_FREE:  nxt = 1'b0;
				RX_LIGHT: nxt = ($urandom_range(0, 4) == 0);
				RX_HEAVY: nxt = ($urandom_range(0, 9) < 6);
				default:  nxt = ~out_stall;
			endcase
		end
		out_stall <= nxt;
	end

	always @(posedge clk) begin : watch_ports
		cache_op_t   op;
		lookup_res_t want;
		if (arst_n) begin
			if (out_valid && !out_stall) begin
				if (lookup_expect.size() == 0) begin
					note_error($sformatf("unexpected result word hit=%0b read_value=%h evicted=%0b",
						hit, read_value, evicted));
				end else begin
					want = lookup_expect.pop_front();
					if (hit !== want.hit || read_value !== want.rd || evicted !== want.ev)
						note_error($sformatf({"result mismatch: hit exp %0b got %0b, ",
							"read_value exp %h got %h, evicted exp %0b got %0b"},
							want.hit, hit, want.rd, read_value, want.ev, evicted));
				end
			end
			if (in_valid && !in_stall) begin
				op.act = action;
				op.k = key;
				op.v = value;
				lookup_expect.push_back(predict_lookup(op));
				op_taken = 1'b1;
			end
		end
	end

	initial begin : run_test
		int i;
		int p;
		int span;
		int unsigned eff;
		arst_n = 1'b0;
		cfg_valid = 1'b0;
		cfg_index = CFG_POLICY;
		cfg_data = '0;
		in_valid = 1'b0;
		action = ACT_INSERT;
		key = '0;
		value = '0;
		out_stall = 1'b0;
		op_taken = 1'b0;
		burst_left = 0;
		gap_left = 0;
		hold_req = 0;
		hold_seen = 0;
		hold_left = 0;
		mode_left = 0;
		stall_mode = RX_FREE;
		err_cnt = 0;
		for (i = 0; i < ENTRIES; i++) begin
			ent_used[i] = 1'b0;
			ent_key[i] = '0;
			ent_val[i] = '0;
			ent_rank[i] = 0;
		end
		ent_fill = 0;
		cur_policy = POL_LRU;
		cur_cap = 16;
		key_pool[0] = '0;
		key_pool[1] = '1;
		key_pool[2] = 32'h8000_0000;
		key_pool[3] = 32'h0000_0001;
		for (i = 4; i < POOL_SIZE; i++)
			key_pool[i] = $urandom;

		repeat (6) @(negedge clk);
		arst_n = 1'b1;

		// reset settings: misses on empty store, extreme keys/values,
		// insert of a present key, the spare action code
		queue_op(ACT_QUERY,  '0, '0);
		queue_op(ACT_CHECK,  '1, '1);
		queue_op(ACT_INSERT, '0, '1);
		queue_op(ACT_INSERT, '1, '0);
		queue_op(ACT_INSERT, '0, 32'h0000_0005);
		queue_op(ACT_QUERY,  '0, '0);
		queue_op(ACT_CHECK,  '1, '0);
		queue_op(ACT_SPARE,  '0, '1);
		queue_op(ACT_QUERY,  '1, '1);
		queue_op(ACT_INSERT, 32'h8000_0000, 32'hA5A5_A5A5);
		wait_drained();

		// FIFO with capacity below occupancy
		write_reg(CFG_POLICY, CAP_BITS'(POL_FIFO));
		write_reg(CFG_CAPACITY, 5'd1);
		queue_op(ACT_INSERT, 32'h0000_0001, 32'h0000_0001);
		queue_op(ACT_INSERT, 32'h0000_0002, 32'h0000_0002);
		queue_op(ACT_QUERY,  32'h0000_0001, '0);
		queue_op(ACT_QUERY,  32'h0000_0002, '0);
		wait_drained();

		// LIFO, capacity zero acts as one
		write_reg(CFG_POLICY, CAP_BITS'(POL_LIFO));
		write_reg(CFG_CAPACITY, 5'd0);
		queue_op(ACT_INSERT, 32'h0000_0003, 32'h1234_5678);
		queue_op(ACT_CHECK,  32'h0000_0003, '0);
		wait_drained();

		// spare policy code acts as LRU, capacity above the table size
		write_reg(CFG_POLICY, 5'd3);
		write_reg(CFG_CAPACITY, 5'd31);
		queue_op(ACT_INSERT, 32'h0000_0004, 32'hFFFF_0000);
		queue_op(ACT_INSERT, 32'h0000_0005, 32'h0000_FFFF);
		queue_op(ACT_QUERY,  32'h0000_0004, '0);
		queue_op(ACT_SPARE,  32'h0000_0005, '0);
		wait_drained();

		for (p = 0; p < PHASES; p++) begin
			write_reg(CFG_POLICY, {3'($urandom_range(0, 7)), 2'(p % 4)});
			write_reg(CFG_CAPACITY, CAP_BITS'(CAP_PLAN[p]));
			eff = (CAP_PLAN[p] == 0) ? 1 : (CAP_PLAN[p] > ENTRIES) ? ENTRIES : CAP_PLAN[p];
			span = eff + $urandom_range(1, 6);
			if (span > POOL_SIZE)
				span = POOL_SIZE;
			if (p == 2)
				hold_req++;
			repeat (PHASE_OPS)
				cache_ops.push_back(rand_op(span));
			wait_drained();
		end

		if (err_cnt == 0)
			$display("Testbench completed without errors");
		else
			$display("Testbench completed WITH ERRORS");
		$finish;
	end

	initial begin : watchdog
		#3_000_000;
		$display("Testbench completed WITH ERRORS");
		$finish;
	end

endmodule
